/* rtl/aat_pkg.sv */
// aat_pkg: shared types and constants for the box affine transform
// no dependencies; imported by every module of the block
package aat_pkg;

    localparam int COEF_W                   = 16;
    localparam int ROW_W                    = 3 * COEF_W;
    localparam int CFG_DATA_W               = 48;
    localparam int CFG_IDX_W                = 3;
    localparam int NUM_AXES                 = 3;
    localparam int NUM_STAGES               = 4;
    localparam int DEF_COORD_WIDTH          = 32;
    localparam int DEF_COEF_FRACTION_BITS   = 12;

    localparam logic [ROW_W-1:0] ROW_X_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_W-1:0] ROW_Y_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_W-1:0] ROW_Z_RESET = 48'h1000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_X   = 3'd0,
        CFG_ROW_Y   = 3'd1,
        CFG_ROW_Z   = 3'd2,
        CFG_SHIFT_X = 3'd3,
        CFG_SHIFT_Y = 3'd4,
        CFG_SHIFT_Z = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } t_stage_ctl;

endpackage

/* rtl/aabb_affine_transform.sv */
// aabb_affine_transform: top level of the box affine transform
// depends on aat_pkg, aat_cfg_regs, aat_pipe_ctl, aat_axis_pipe
//
// Takes one box per beat and returns its transformed bounding box; a new box
// may enter every cycle unless the pipe is full and stalled. The box bounds
// are never formed as eight corners: each output axis runs its own four-stage
// pipe (multiply, floor shift with bound select, sum with translation,
// saturate) with six coordinate-by-coefficient multipliers, eighteen in all,
// which set the clock. While the output stalls, stages move only into gaps.
// Configuration must be written only when the pipe is idle; not enforced.
module aabb_affine_transform #(
    parameter int COORD_WIDTH        = aat_pkg::DEF_COORD_WIDTH,
    parameter int COEF_FRACTION_BITS = aat_pkg::DEF_COEF_FRACTION_BITS,
    parameter int DATA_W             = ((6 * COORD_WIDTH + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wen,
    input  logic [aat_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [aat_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z
    input  logic [DATA_W-1:0]               s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z
    output logic [DATA_W-1:0]               m_axis_tdata
);
    import aat_pkg::*;

    logic [ROW_W-1:0]              w_row   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_shift [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_lo    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_hi    [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_min   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] w_max   [NUM_AXES];
    logic [6*COORD_WIDTH-1:0]      w_out_fields;
    t_stage_ctl                    w_ctl;

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_lo[a] = s_axis_tdata[a*COORD_WIDTH +: COORD_WIDTH];
            w_hi[a] = s_axis_tdata[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    aat_cfg_regs #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_row       (w_row),
        .o_shift     (w_shift)
    );

    aat_pipe_ctl u_ctl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_ctl       (w_ctl)
    );

    for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
        aat_axis_pipe #(
            .COORD_WIDTH        (COORD_WIDTH),
            .COEF_FRACTION_BITS (COEF_FRACTION_BITS)
        ) u_axis (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_lo    (w_lo),
            .i_hi    (w_hi),
            .i_row   (w_row[a]),
            .i_shift (w_shift[a]),
            .o_min   (w_min[a]),
            .o_max   (w_max[a])
        );
    end

    always_comb begin
        for (int a = 0; a < NUM_AXES; a++) begin
            w_out_fields[a*COORD_WIDTH +: COORD_WIDTH]            = w_min[a];
            w_out_fields[(a+NUM_AXES)*COORD_WIDTH +: COORD_WIDTH] = w_max[a];
        end
    end

    assign m_axis_tdata = DATA_W'(w_out_fields);

endmodule

/* rtl/aat_cfg_regs.sv */
// aat_cfg_regs: transform coefficient rows and translation registers
// depends on aat_pkg
module aat_cfg_regs #(
    parameter int COORD_WIDTH = aat_pkg::DEF_COORD_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_wen,
    input  logic [aat_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [aat_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    output logic [aat_pkg::ROW_W-1:0]           o_row   [aat_pkg::NUM_AXES],
    output logic signed [COORD_WIDTH-1:0]       o_shift [aat_pkg::NUM_AXES]
);
    import aat_pkg::*;

    logic [ROW_W-1:0]              r_row   [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] r_shift [NUM_AXES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row[0]   <= ROW_X_RESET;
            r_row[1]   <= ROW_Y_RESET;
            r_row[2]   <= ROW_Z_RESET;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
        end else if (i_cfg_wen) begin
            case (i_cfg_idx)
                CFG_ROW_X:   r_row[0]   <= i_cfg_wdata[ROW_W-1:0];
                CFG_ROW_Y:   r_row[1]   <= i_cfg_wdata[ROW_W-1:0];
                CFG_ROW_Z:   r_row[2]   <= i_cfg_wdata[ROW_W-1:0];
                CFG_SHIFT_X: r_shift[0] <= i_cfg_wdata[COORD_WIDTH-1:0];
                CFG_SHIFT_Y: r_shift[1] <= i_cfg_wdata[COORD_WIDTH-1:0];
                CFG_SHIFT_Z: r_shift[2] <= i_cfg_wdata[COORD_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign o_row   = r_row;
    assign o_shift = r_shift;

endmodule

/* rtl/aat_axis_pipe.sv */
// aat_axis_pipe: four-stage datapath for one output axis
// multiply, floor shift and bound select, sum, saturate; depends on aat_pkg
module aat_axis_pipe #(
    parameter int COORD_WIDTH        = aat_pkg::DEF_COORD_WIDTH,
    parameter int COEF_FRACTION_BITS = aat_pkg::DEF_COEF_FRACTION_BITS
) (
    input  logic                                i_clk,
    input  aat_pkg::t_stage_ctl                 i_ctl,
    input  logic signed [COORD_WIDTH-1:0]       i_lo    [aat_pkg::NUM_AXES],
    input  logic signed [COORD_WIDTH-1:0]       i_hi    [aat_pkg::NUM_AXES],
    input  logic [aat_pkg::ROW_W-1:0]           i_row,
    input  logic signed [COORD_WIDTH-1:0]       i_shift,
    output logic signed [COORD_WIDTH-1:0]       o_min,
    output logic signed [COORD_WIDTH-1:0]       o_max
);
    import aat_pkg::*;

    localparam int PW   = COORD_WIDTH + COEF_W;
    localparam int SW   = PW - COEF_FRACTION_BITS;
    localparam int SUMW = SW + 2;

    logic signed [COEF_W-1:0]      w_coef  [NUM_AXES];
    logic signed [PW-1:0]          r_p_lo  [NUM_AXES];
    logic signed [PW-1:0]          r_p_hi  [NUM_AXES];
    logic signed [PW-1:0]          w_s_lo  [NUM_AXES];
    logic signed [PW-1:0]          w_s_hi  [NUM_AXES];
    logic signed [SW-1:0]          w_f_lo  [NUM_AXES];
    logic signed [SW-1:0]          w_f_hi  [NUM_AXES];
    logic signed [SW-1:0]          r_t_min [NUM_AXES];
    logic signed [SW-1:0]          r_t_max [NUM_AXES];
    logic signed [SUMW-1:0]        r_sum_min;
    logic signed [SUMW-1:0]        r_sum_max;
    logic signed [COORD_WIDTH-1:0] n_min;
    logic signed [COORD_WIDTH-1:0] n_max;
    logic signed [COORD_WIDTH-1:0] r_min;
    logic signed [COORD_WIDTH-1:0] r_max;

    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            w_coef[j] = i_row[j*COEF_W +: COEF_W];
        end
    end

    // stage 1: exact products of both bounds
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[0]) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r_p_lo[j] <= PW'(i_lo[j]) * PW'(w_coef[j]);
                r_p_hi[j] <= PW'(i_hi[j]) * PW'(w_coef[j]);
            end
        end
    end

    // stage 2: floor shift, then pick the smaller and larger term per input axis
    always_comb begin
        for (int j = 0; j < NUM_AXES; j++) begin
            w_s_lo[j] = r_p_lo[j] >>> COEF_FRACTION_BITS;
            w_s_hi[j] = r_p_hi[j] >>> COEF_FRACTION_BITS;
            w_f_lo[j] = w_s_lo[j][SW-1:0];
            w_f_hi[j] = w_s_hi[j][SW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[1]) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r_t_min[j] <= (w_f_lo[j] < w_f_hi[j]) ? w_f_lo[j] : w_f_hi[j];
                r_t_max[j] <= (w_f_lo[j] < w_f_hi[j]) ? w_f_hi[j] : w_f_lo[j];
            end
        end
    end

    // stage 3: translation plus the three selected terms
    always_ff @(posedge i_clk) begin
        if (i_ctl.load[2]) begin
            r_sum_min <= SUMW'(i_shift) + SUMW'(r_t_min[0])
                       + SUMW'(r_t_min[1]) + SUMW'(r_t_min[2]);
            r_sum_max <= SUMW'(i_shift) + SUMW'(r_t_max[0])
                       + SUMW'(r_t_max[1]) + SUMW'(r_t_max[2]);
        end
    end

    // stage 4: clamp to the coordinate range
    always_comb begin
        if ((&r_sum_min[SUMW-1:COORD_WIDTH-1]) || !(|r_sum_min[SUMW-1:COORD_WIDTH-1])) begin
            n_min = r_sum_min[COORD_WIDTH-1:0];
        end else if (r_sum_min[SUMW-1]) begin
            n_min = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            n_min = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
        if ((&r_sum_max[SUMW-1:COORD_WIDTH-1]) || !(|r_sum_max[SUMW-1:COORD_WIDTH-1])) begin
            n_max = r_sum_max[COORD_WIDTH-1:0];
        end else if (r_sum_max[SUMW-1]) begin
            n_max = {1'b1, {(COORD_WIDTH-1){1'b0}}};
        end else begin
            n_max = {1'b0, {(COORD_WIDTH-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load[3]) begin
            r_min <= n_min;
            r_max <= n_max;
        end
    end

    assign o_min = r_min;
    assign o_max = r_max;

endmodule

/* rtl/aat_pipe_ctl.sv */
// aat_pipe_ctl: stage valid bits and per-stage load enables with stall handling
// depends on aat_pkg
module aat_pipe_ctl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output aat_pkg::t_stage_ctl o_ctl
);
    import aat_pkg::*;

    logic [NUM_STAGES-1:0] r_valid;
    logic [NUM_STAGES-1:0] w_adv;
    logic [NUM_STAGES-1:0] w_src;

    // a stage moves when it is empty or the one after it moves
    always_comb begin
        w_adv[NUM_STAGES-1] = !r_valid[NUM_STAGES-1] || i_out_ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_adv[k] = !r_valid[k] || w_adv[k+1];
        end
        w_src[0] = i_in_valid;
        for (int k = 1; k < NUM_STAGES; k++) begin
            w_src[k] = r_valid[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            for (int k = 0; k < NUM_STAGES; k++) begin
                if (w_adv[k]) begin
                    r_valid[k] <= w_src[k];
                end
            end
        end
    end

    assign o_ctl.load  = w_adv & w_src;
    assign o_in_ready  = w_adv[0];
    assign o_out_valid = r_valid[NUM_STAGES-1];

endmodule
